// ----- design/ast_pkg.sv -----
// ast_pkg: shared constants, codes and types for the alarm state table
// used by alarm_state_table; depends on nothing
`default_nettype none
package ast_pkg;

   localparam int ENTRIES = 32;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_W = $clog2(ENTRIES + 1);
   localparam int KEY_W   = 24;
   localparam int LEVEL_W = 8;
   localparam int ACT_W   = 6;

   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_LIST   = 1'b1;

   typedef enum logic [1:0] {
      STAT_APPENDED = 2'd0,
      STAT_UPDATED  = 2'd1,
      STAT_DROPPED  = 2'd2,
      STAT_LIST     = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   localparam logic [LEVEL_W-1:0] LEVEL_ACT_LO = 8'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_ACT_HI = 8'd2;

   function automatic logic is_active(input logic [LEVEL_W-1:0] lvl);
      return (lvl == LEVEL_ACT_LO) || (lvl == LEVEL_ACT_HI);
   endfunction

endpackage
`default_nettype wire

// ----- design/alarm_state_table.sv -----
// alarm_state_table: a report scans the used slots in order and stops on a key hit; a list scans every used slot
// on an empty table either kind finishes with no slot read
// each result is registered and reaches the rsp ports in the cycle after its scan cycle, at most one per cycle
// busy stays high for the whole scan; a new transaction is accepted only while busy is low
// synchronous reset empties the table (fill count zero); ram contents are not cleared
// results are strobed for one cycle on rsp_valid; the receiver cannot stall them; ast_pkg, ast_ram
`default_nettype none
module alarm_state_table (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_opcode,
   input  wire logic [7:0] req_plug,
   input  wire logic [7:0] req_unit,
   input  wire logic [7:0] req_sub_unit,
   input  wire logic [7:0] req_level,
   // result channel
   output logic            rsp_valid,
   output logic [1:0]      rsp_status,
   output logic            rsp_entry_present,
   output logic [7:0]      rsp_out_plug,
   output logic [7:0]      rsp_out_unit,
   output logic [7:0]      rsp_out_sub_unit,
   output logic [7:0]      rsp_out_level,
   output logic [5:0]      rsp_active_count,
   output logic            rsp_last
);
   import ast_pkg::*;

   // sequencer state
   state_type state_ff, state_in;

   // latched transaction
   logic               op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in;

   // table occupancy
   logic [COUNT_W-1:0] fill_ff, fill_in;

   // scan pointer and read pipeline
   logic [COUNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_tag_ff, rd_tag_in;

   // held-back list entry, so the last one can be marked
   logic               pend_vld_ff, pend_vld_in;
   logic [KEY_W-1:0]   pend_key_ff, pend_key_in;
   logic [LEVEL_W-1:0] pend_lvl_ff, pend_lvl_in;
   logic [ACT_W-1:0]   pend_cnt_ff, pend_cnt_in;
   logic [ACT_W-1:0]   act_cnt_ff, act_cnt_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_present_ff, rsp_present_in;
   logic [KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic [ACT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   // ram ports
   logic               key_we;
   logic [IDX_W-1:0]   key_waddr;
   logic [KEY_W-1:0]   key_rdata;
   logic               lvl_we;
   logic [IDX_W-1:0]   lvl_waddr;
   logic [LEVEL_W-1:0] lvl_wdata;
   logic [LEVEL_W-1:0] lvl_rdata;

   // scan events
   logic accept;
   logic issue;
   logic hit;
   logic active_hit;
   logic scan_done;

   ast_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_ff),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (key_rdata)
   );

   ast_ram #(.WIDTH(LEVEL_W), .DEPTH(ENTRIES)) u_level_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (lvl_waddr),
      .wr_data (lvl_wdata),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (lvl_rdata)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // a report stops on the first slot whose key matches
   assign hit = (state_ff == ST_SCAN) && (op_ff == OP_REPORT) && rd_vld_ff
                && (key_rdata == key_ff);
   assign active_hit = (state_ff == ST_SCAN) && (op_ff == OP_LIST) && rd_vld_ff
                       && is_active(lvl_rdata);
   // every used slot issued and its data seen
   assign scan_done = (state_ff == ST_SCAN) && (rd_idx_ff == fill_ff) && !rd_vld_ff;
   assign issue = (state_ff == ST_SCAN) && (rd_idx_ff < fill_ff) && !hit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit || scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in          = op_ff;
      key_in         = key_ff;
      lvl_in         = lvl_ff;
      fill_in        = fill_ff;
      rd_idx_in      = rd_idx_ff;
      rd_vld_in      = 1'b0;
      rd_tag_in      = rd_tag_ff;
      pend_vld_in    = pend_vld_ff;
      pend_key_in    = pend_key_ff;
      pend_lvl_in    = pend_lvl_ff;
      pend_cnt_in    = pend_cnt_ff;
      act_cnt_in     = act_cnt_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = STAT_LIST;
      rsp_present_in = 1'b0;
      rsp_key_in     = '0;
      rsp_level_in   = '0;
      rsp_count_in   = '0;
      rsp_last_in    = 1'b1;
      key_we         = 1'b0;
      key_waddr      = fill_ff[IDX_W-1:0];
      lvl_we         = 1'b0;
      lvl_waddr      = fill_ff[IDX_W-1:0];
      lvl_wdata      = lvl_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_opcode;
               key_in      = {req_plug, req_unit, req_sub_unit};
               lvl_in      = req_level;
               rd_idx_in   = '0;
               pend_vld_in = 1'b0;
               act_cnt_in  = '0;
            end
         end
         ST_SCAN: begin
            // one slot read issued per cycle until every used slot is read or a report hits
            if (issue) begin
               rd_vld_in = 1'b1;
               rd_tag_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in = COUNT_W'(rd_idx_ff + 1'b1);
            end

            if (hit) begin
               // key found: overwrite its level in place
               lvl_we        = 1'b1;
               lvl_waddr     = rd_tag_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_UPDATED;
            end

            if (active_hit) begin
               // release the previous active entry, hold this one back
               if (pend_vld_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_present_in = 1'b1;
                  rsp_key_in     = pend_key_ff;
                  rsp_level_in   = pend_lvl_ff;
                  rsp_count_in   = pend_cnt_ff;
                  rsp_last_in    = 1'b0;
               end
               pend_vld_in = 1'b1;
               pend_key_in = key_rdata;
               pend_lvl_in = lvl_rdata;
               pend_cnt_in = ACT_W'(act_cnt_ff + 1'b1);
               act_cnt_in  = ACT_W'(act_cnt_ff + 1'b1);
            end

            if (scan_done) begin
               rsp_valid_in = 1'b1;
               if (op_ff == OP_REPORT) begin
                  if (fill_ff < COUNT_W'(ENTRIES)) begin
                     // key absent: append in the next free slot
                     key_we        = 1'b1;
                     lvl_we        = 1'b1;
                     fill_in       = COUNT_W'(fill_ff + 1'b1);
                     rsp_status_in = STAT_APPENDED;
                  end else begin
                     rsp_status_in = STAT_DROPPED;
                  end
               end else if (pend_vld_ff) begin
                  // final active entry carries the last flag
                  rsp_present_in = 1'b1;
                  rsp_key_in     = pend_key_ff;
                  rsp_level_in   = pend_lvl_ff;
                  rsp_count_in   = pend_cnt_ff;
               end
               // otherwise the empty list result from the defaults
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
         act_cnt_ff   <= '0;
         rd_idx_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_vld_ff  <= pend_vld_in;
         act_cnt_ff   <= act_cnt_in;
         rd_idx_ff    <= rd_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      lvl_ff         <= lvl_in;
      rd_tag_ff      <= rd_tag_in;
      pend_key_ff    <= pend_key_in;
      pend_lvl_ff    <= pend_lvl_in;
      pend_cnt_ff    <= pend_cnt_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_present_ff <= rsp_present_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_present = rsp_present_ff;
   assign rsp_out_plug      = rsp_key_ff[23:16];
   assign rsp_out_unit      = rsp_key_ff[15:8];
   assign rsp_out_sub_unit  = rsp_key_ff[7:0];
   assign rsp_out_level     = rsp_level_ff;
   assign rsp_active_count  = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

   // occupancy never passes the table size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= COUNT_W'(ENTRIES))
      else $error("fill count beyond table size");

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");

   // no slot read left in flight once the scan has ended
   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rd_vld_ff)
      else $error("read in flight while idle");

   // report results are single, final and carry no entry
   a_report_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_LIST)) |-> (rsp_last && !rsp_entry_present))
      else $error("malformed report result");

endmodule
`default_nettype wire

// ----- design/ast_ram.sv -----
// ast_ram: generic single write port, single read port ram with registered read
// stand-alone, no package needed
`default_nettype none
module ast_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire
